// ===== design/spdf_pkg.sv =====
// Package for the sync pair packet deframer.
// Holds the result word type, the sync bytes and the body mode codes.
// No dependencies.
`timescale 1ns / 1ps

package spdf_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 7;

    // Sync pair, first and second byte.
    localparam logic [BYTE_W-1:0] SYNC_HI = 8'hBE;
    localparam logic [BYTE_W-1:0] SYNC_LO = 8'hEF;

    // Body mode codes. The unused code acts as hunting.
    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_SKIP = 2'd1;
    localparam logic [1:0] MODE_KEEP = 2'd2;

    // One result word handed from the framer to the output stage.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
    } t_result;

endpackage

// ===== design/spdf_frame_fsm.sv =====
// Framing state machine of the sync pair packet deframer.
// Hunts aligned sync pairs, tracks body position and emits kept bytes.
// Depends on spdf_pkg.
`timescale 1ns / 1ps

module spdf_frame_fsm import spdf_pkg::*; #(
    parameter int DATA_LEN = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_produce,
    output t_result           o_result
);

    localparam logic [INDEX_W-1:0] DATA_END = INDEX_W'(DATA_LEN);
    localparam logic [INDEX_W-1:0] BODY_END = INDEX_W'(DATA_LEN + 2);

    logic               r_pair_second, n_pair_second;
    logic [BYTE_W-1:0]  r_held_byte, n_held_byte;
    logic [1:0]         r_mode, n_mode;
    logic [INDEX_W-1:0] r_pos, n_pos;
    logic               r_saw_first, n_saw_first;

    logic in_body;

    assign in_body = (r_mode == MODE_SKIP) || (r_mode == MODE_KEEP);

    // A kept packet emits its type byte and its data bytes.
    assign o_produce           = (r_mode == MODE_KEEP) && (r_pos <= DATA_END);
    assign o_result.out_byte   = i_byte;
    assign o_result.byte_index = r_pos;
    assign o_result.last       = (r_pos == DATA_END);

    // Next state for the byte now being consumed.
    always_comb begin
        n_pair_second = r_pair_second;
        n_held_byte   = r_held_byte;
        n_mode        = r_mode;
        n_pos         = r_pos;
        n_saw_first   = r_saw_first;
        if (in_body) begin
            if (r_pos >= BODY_END) begin
                n_mode        = MODE_HUNT;
                n_pos         = '0;
                n_pair_second = 1'b0;
            end else begin
                n_pos = r_pos + INDEX_W'(1);
            end
        end else begin
            n_mode = MODE_HUNT;
            if (!r_pair_second) begin
                n_held_byte   = i_byte;
                n_pair_second = 1'b1;
            end else begin
                n_pair_second = 1'b0;
                if ((r_held_byte == SYNC_HI) && (i_byte == SYNC_LO)) begin
                    n_pos       = '0;
                    n_saw_first = !r_saw_first;
                    n_mode      = r_saw_first ? MODE_KEEP : MODE_SKIP;
                end
            end
        end
    end

    // State registers advance once per consumed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_second <= 1'b0;
            r_held_byte   <= '0;
            r_mode        <= MODE_HUNT;
            r_pos         <= '0;
            r_saw_first   <= 1'b0;
        end else if (i_step) begin
            r_pair_second <= n_pair_second;
            r_held_byte   <= n_held_byte;
            r_mode        <= n_mode;
            r_pos         <= n_pos;
            r_saw_first   <= n_saw_first;
        end
    end

endmodule

// ===== design/spdf_out_skid.sv =====
// Output stage of the sync pair packet deframer.
// An output register backed by one skid entry, so the framer sees a registered ready.
// Depends on spdf_pkg.
`timescale 1ns / 1ps

module spdf_out_skid import spdf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  t_result            i_result,
    output logic               o_full,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic [INDEX_W-1:0] o_byte_index,
    output logic               o_last
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_sk_valid;
    t_result r_sk;
    logic    take;

    assign take   = r_out_valid && !i_out_stall;
    assign o_full = r_sk_valid;

    // Valid flags for the output word and the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (take) begin
            r_out_valid <= r_sk_valid || i_wr;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid) begin
            r_out_valid <= i_wr;
        end else if (i_wr) begin
            r_sk_valid <= 1'b1;
        end
    end

    // Payload: the skid word drains first, a new word fills whichever slot is free.
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_sk_valid) begin
                r_out <= r_sk;
            end else if (i_wr) begin
                r_out <= i_result;
            end
        end else if (!r_out_valid) begin
            if (i_wr) begin
                r_out <= i_result;
            end
        end else if (i_wr) begin
            r_sk <= i_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_byte_index = r_out.byte_index;
    assign o_last       = r_out.last;

endmodule

// ===== design/sync_pair_packet_deframer.sv =====
// Sync pair packet deframer: takes one received byte per word and one byte per clock in
// steady state. A byte passes an input register, then the framing state machine, which
// writes an output register. The input stalls only while the one-entry skid behind
// the output register is occupied, so a downstream stall reaches the input once it fills the skid.
// Aligned byte pairs are hunted for 0xBE,0xEF; packets alternate skipped and kept, the first
// skipped. A kept packet yields its type byte (index 0) and DATA_LEN data bytes, the final
// one flagged last; checksum bytes are consumed unchecked. Depends on spdf_pkg,
// spdf_frame_fsm and spdf_out_skid.
`timescale 1ns / 1ps

module sync_pair_packet_deframer import spdf_pkg::*; #(
    parameter int DATA_LEN = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic [INDEX_W-1:0] o_byte_index,
    output logic               o_last
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              produce;
    logic              out_full;
    logic              step;
    logic              in_accept;
    t_result           result;

    // The held word moves on when it yields nothing or the output stage has room.
    assign step       = r_in_valid && (!produce || !out_full);
    assign o_in_stall = r_in_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    spdf_frame_fsm #(
        .DATA_LEN (DATA_LEN)
    ) u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .o_produce (produce),
        .o_result  (result)
    );

    spdf_out_skid u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (step && produce),
        .i_result     (result),
        .o_full       (out_full),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_index (o_byte_index),
        .o_last       (o_last)
    );

endmodule
